// File: design/subpixel_bilinear_shift_unit_macros.svh
// Assertion macros for the sub-pixel bilinear shift unit checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef SUBPIXEL_BILINEAR_SHIFT_UNIT_MACROS_SVH
`define SUBPIXEL_BILINEAR_SHIFT_UNIT_MACROS_SVH

// Same-cycle implication.
`define SBS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sbs assertion failed");

// Next-cycle implication.
`define SBS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sbs assertion failed");

`endif

// File: design/sbs_pkg.sv
// Shared types and constants for the sub-pixel bilinear shift unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

  localparam int FRACTION_BITS_DEF = 4;
  localparam int MAX_ROW_BYTES_DEF = 4096;
  localparam int MAX_CHANNELS_DEF  = 4;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int FRAC_W      = 4;
  localparam int CHAN_W      = 3;
  localparam int GEOM_W      = 13;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAC_X        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAC_Y        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT     = 3'd4;

  // Per-byte control from the position tracker
  typedef struct packed {
    logic emit;
    logic row_last;
    logic frame_last;
  } pos_flags_t;

endpackage

`default_nettype wire

// File: design/sbs_pos_ctrl.sv
// Column/row tracker: clamps geometry, gives line store address and per-byte flags.
// Depends on sbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbs_pos_ctrl #(
  parameter int MAX_ROW_BYTES = sbs_pkg::MAX_ROW_BYTES_DEF,
  parameter int ADDR_W        = $clog2(MAX_ROW_BYTES)
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           step,
  input  wire [3:0]                     channels,
  input  wire [sbs_pkg::GEOM_W-1:0]     row_bytes,
  input  wire [sbs_pkg::GEOM_W-1:0]     row_count,
  output logic [ADDR_W-1:0]             addr,
  output sbs_pkg::pos_flags_t           flags
);

  localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMP_W = (RB_W > sbs_pkg::GEOM_W) ? RB_W : sbs_pkg::GEOM_W;

  logic [ADDR_W-1:0]          col;
  logic [sbs_pkg::GEOM_W-1:0] row;

  logic [CMP_W-1:0]           rb_raw;
  logic [CMP_W-1:0]           rb;
  logic [CMP_W-1:0]           c_ext;
  logic [sbs_pkg::GEOM_W-1:0] rc;
  logic [sbs_pkg::GEOM_W-1:0] r;
  logic                       last_col;
  logic                       last_frame;

  always_comb begin
    rb_raw = CMP_W'(row_bytes);
    if (rb_raw == '0) begin
      rb = CMP_W'(1);
    end else if (rb_raw > CMP_W'(MAX_ROW_BYTES)) begin
      rb = CMP_W'(MAX_ROW_BYTES);
    end else begin
      rb = rb_raw;
    end
    // saturate to the last column if geometry shrank
    c_ext = (CMP_W'(col) < rb) ? CMP_W'(col) : rb - CMP_W'(1);
    addr  = c_ext[ADDR_W-1:0];

    rc = (row_count == '0) ? sbs_pkg::GEOM_W'(1) : row_count;
    r  = (row < rc) ? row : rc;

    last_col   = (c_ext == rb - CMP_W'(1));
    last_frame = last_col && (r == rc);

    flags.emit       = (r != '0) && (c_ext >= CMP_W'(channels));
    flags.row_last   = last_col;
    flags.frame_last = last_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (last_col) begin
        col <= '0;
        row <= last_frame ? '0 : r + sbs_pkg::GEOM_W'(1);
      end else begin
        col <= addr + ADDR_W'(1);
        row <= r;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/sbs_line_mem.sv
// Previous-row line store, one port, read-before-write, registered read data.
// Depends on sbs_pkg (defaults only).
`timescale 1ns / 1ps
`default_nettype none

module sbs_line_mem #(
  parameter int DEPTH  = sbs_pkg::MAX_ROW_BYTES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire               clk,
  input  wire               en,
  input  wire [ADDR_W-1:0]  addr,
  input  wire [7:0]         wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: design/sbs_blend.sv
// Channel delay lines, bilinear weights and the four-tap weighted sum.
// Depends on sbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbs_blend #(
  parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF,
  parameter int MAX_CHANNELS  = sbs_pkg::MAX_CHANNELS_DEF,
  parameter int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire                        clk,
  input  wire                        shift,
  input  wire [sbs_pkg::FRAC_W-1:0]  frac_x,
  input  wire [sbs_pkg::FRAC_W-1:0]  frac_y,
  input  wire [CH_W-1:0]             ch_idx,
  input  wire [7:0]                  tap_b,
  input  wire [7:0]                  tap_e,
  output logic [7:0]                 pixel
);

  localparam int FB    = FRACTION_BITS;
  localparam int W_W   = 2 * FB + 1;
  localparam int ACC_W = 8 + 2 * FB;

  logic [7:0]     cur_dly  [MAX_CHANNELS];
  logic [7:0]     prev_dly [MAX_CHANNELS];
  logic [W_W-1:0] w_a, w_b, w_d, w_e;

  logic [FB-1:0]    fx, fy;
  logic [FB:0]      omx, omy;
  logic [7:0]       tap_a, tap_d;
  logic [ACC_W-1:0] acc;

  assign fx  = FB'(frac_x);
  assign fy  = FB'(frac_y);
  assign omx = (FB + 1)'(1 << FB) - (FB + 1)'(fx);
  assign omy = (FB + 1)'(1 << FB) - (FB + 1)'(fy);

  // weights depend on configuration only
  always_ff @(posedge clk) begin
    w_a <= W_W'(omx * omy);
    w_b <= W_W'((FB + 1)'(fx) * omy);
    w_d <= W_W'(omx * (FB + 1)'(fy));
    w_e <= W_W'(fx * fy);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      cur_dly[0]  <= tap_e;
      prev_dly[0] <= tap_b;
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        cur_dly[k]  <= cur_dly[k-1];
        prev_dly[k] <= prev_dly[k-1];
      end
    end
  end

  assign tap_a = prev_dly[ch_idx];
  assign tap_d = cur_dly[ch_idx];

  always_comb begin
    acc = ACC_W'(tap_a) * ACC_W'(w_a)
        + ACC_W'(tap_b) * ACC_W'(w_b)
        + ACC_W'(tap_d) * ACC_W'(w_d)
        + ACC_W'(tap_e) * ACC_W'(w_e)
        + ACC_W'(1 << (2 * FB - 1));
    pixel = acc[2*FB +: 8];
  end

endmodule

`default_nettype wire

// File: design/subpixel_bilinear_shift_unit.sv
// Top level of the sub-pixel bilinear shift unit.
// Depends on sbs_pkg, sbs_pos_ctrl, sbs_line_mem, sbs_blend.
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   sample    | sample_valid, sample_stall, sample        | in
//   pixel     | pixel_valid, pixel_stall, pixel,          | out
//             | row_last, frame_last                      |
//   config    | cfg_we, cfg_index, cfg_data               | in
//
// One transaction per clock while sample_stall is low: one line store read and
// write per accepted byte. An accepted byte passes stage 1, then the output
// register, which raises pixel_valid if the byte yields a result.
// Synchronous reset clears positions, valids and configuration registers, not the line
// store or the delay lines.
// sample_stall: stage and output register both full while pixel_stall holds.
`timescale 1ns / 1ps
`default_nettype none

module subpixel_bilinear_shift_unit #(
  parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF,
  parameter int MAX_ROW_BYTES = sbs_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_CHANNELS  = sbs_pkg::MAX_CHANNELS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // source bytes
  input  wire                              sample_valid,
  output logic                             sample_stall,
  input  wire [7:0]                        sample,
  // interpolated bytes
  output logic                             pixel_valid,
  input  wire                              pixel_stall,
  output logic [7:0]                       pixel,
  output logic                             row_last,
  output logic                             frame_last,
  // configuration writes
  input  wire                              cfg_we,
  input  wire [sbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [sbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // configuration registers
  logic [sbs_pkg::FRAC_W-1:0] frac_x;
  logic [sbs_pkg::FRAC_W-1:0] frac_y;
  logic [sbs_pkg::CHAN_W-1:0] channel_count;
  logic [sbs_pkg::GEOM_W-1:0] row_bytes;
  logic [sbs_pkg::GEOM_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_x        <= '0;
      frac_y        <= '0;
      channel_count <= sbs_pkg::CHAN_W'(1);
      row_bytes     <= sbs_pkg::GEOM_W'(64);
      row_count     <= sbs_pkg::GEOM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbs_pkg::REG_FRAC_X:        frac_x        <= cfg_data[sbs_pkg::FRAC_W-1:0];
        sbs_pkg::REG_FRAC_Y:        frac_y        <= cfg_data[sbs_pkg::FRAC_W-1:0];
        sbs_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[sbs_pkg::CHAN_W-1:0];
        sbs_pkg::REG_ROW_BYTES:     row_bytes     <= cfg_data[sbs_pkg::GEOM_W-1:0];
        sbs_pkg::REG_ROW_COUNT:     row_count     <= cfg_data[sbs_pkg::GEOM_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // tap distance, clamped to 1..MAX_CHANNELS
  logic [3:0]      ch_val;
  logic [CH_W-1:0] ch_idx;

  always_comb begin
    if (channel_count == '0) begin
      ch_val = 4'd1;
    end else if (4'(channel_count) > 4'(MAX_CHANNELS)) begin
      ch_val = 4'(MAX_CHANNELS);
    end else begin
      ch_val = 4'(channel_count);
    end
    ch_idx = CH_W'(ch_val - 4'd1);
  end

  // pipeline control: stage 1 holds the byte whose line store read is in flight
  logic                 s1_valid;
  logic [7:0]           s1_e;
  sbs_pkg::pos_flags_t  s1_flags;
  logic                 advance;
  logic                 accept;

  assign advance      = !pixel_valid || !pixel_stall;
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  logic [ADDR_W-1:0]    rd_addr;
  sbs_pkg::pos_flags_t  pos_flags;
  logic [7:0]           tap_b;
  logic [7:0]           blend_pixel;

  sbs_pos_ctrl #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .ADDR_W        (ADDR_W)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .channels  (ch_val),
    .row_bytes (row_bytes),
    .row_count (row_count),
    .addr      (rd_addr),
    .flags     (pos_flags)
  );

  // read old row byte and store the new one in the same transaction
  sbs_line_mem #(
    .DEPTH  (MAX_ROW_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .en    (accept),
    .addr  (rd_addr),
    .wdata (sample),
    .rdata (tap_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_e     <= sample;
      s1_flags <= pos_flags;
    end
  end

  // delay lines shift once per byte, whether or not it produces a result
  sbs_blend #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_CHANNELS  (MAX_CHANNELS),
    .CH_W          (CH_W)
  ) u_blend (
    .clk    (clk),
    .shift  (s1_valid && advance),
    .frac_x (frac_x),
    .frac_y (frac_y),
    .ch_idx (ch_idx),
    .tap_b  (tap_b),
    .tap_e  (s1_e),
    .pixel  (blend_pixel)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= s1_valid && s1_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel      <= blend_pixel;
      row_last   <= s1_flags.row_last;
      frame_last <= s1_flags.frame_last;
    end
  end

endmodule

`default_nettype wire

// File: design/sbs_checker.sv
// Port-level checker for the sub-pixel bilinear shift unit, bound to the top level.
// Depends on subpixel_bilinear_shift_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "subpixel_bilinear_shift_unit_macros.svh"

module sbs_checker (
  input wire       clk,
  input wire       rst,
  input wire       sample_valid,
  input wire       sample_stall,
  input wire       pixel_valid,
  input wire       pixel_stall,
  input wire [7:0] pixel,
  input wire       row_last,
  input wire       frame_last
);

  // held result does not move while stalled
  `SBS_ASSERT_NEXT(a_out_hold, pixel_valid && pixel_stall, pixel_valid && $stable({pixel, row_last, frame_last}))

  // end of frame is always an end of row
  `SBS_ASSERT_NOW(a_frame_row, pixel_valid && frame_last, row_last)

  // input only backs up behind a stalled result
  `SBS_ASSERT_NOW(a_stall_cause, sample_stall, pixel_valid && pixel_stall)

  // a new result follows an input transaction through stage 1 and the output register
  `SBS_ASSERT_NOW(a_latency, $rose(pixel_valid), $past(sample_valid && !sample_stall, 2))

endmodule

bind subpixel_bilinear_shift_unit sbs_checker u_sbs_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .row_last     (row_last),
  .frame_last   (frame_last)
);

`default_nettype wire

// File: tb/tb_subpixel_bilinear_shift_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for subpixel_bilinear_shift_unit: streams source bytes,
// programs the shift registers and compares every interpolated byte with a
// local prediction. Depends on sbs_pkg and the unit's RTL.
module tb_subpixel_bilinear_shift_unit;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  // pipeline is two deep; spare cycles let it empty before touching the registers
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BYTES  = 1250;
  localparam int MAX_REPORTS   = 40;
  localparam int FB            = sbs_pkg::FRACTION_BITS_DEF;
  localparam int ONE           = 1 << FB;
  localparam int MAX_RB        = sbs_pkg::MAX_ROW_BYTES_DEF;
  localparam int MAX_CH        = sbs_pkg::MAX_CHANNELS_DEF;
  // indexes past the last register decode to nothing
  localparam logic [sbs_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST =
    sbs_pkg::REG_ROW_COUNT + 1'b1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
    logic       frame_last;
  } pixel_txn_t;

  // ---------------------------------------------------------------------
  // DUT and its ports; every input starts at a known value
  // ---------------------------------------------------------------------
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  logic [7:0]                      sample = 8'd0;
  logic                            pixel_valid;
  logic                            pixel_stall = 1'b0;
  logic [7:0]                      pixel;
  logic                            row_last;
  logic                            frame_last;
  logic                            cfg_we = 1'b0;
  logic [sbs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sbs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  subpixel_bilinear_shift_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .row_last     (row_last),
    .frame_last   (frame_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------
  logic [7:0]  pending_samples[$];   // bytes waiting for the driver
  pixel_txn_t  expected_pixels[$];   // predicted output, oldest first

  int unsigned sender_gap_pct     = 23;
  int unsigned receiver_stall_pct = 78;

  int unsigned cycles         = 0;
  int unsigned bytes_in       = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_done    = 0;
  int unsigned reg_writes     = 0;
  int unsigned bad_pixels     = 0;

  // Shadow of the unit: registers as written, line of the previous source
  // row, per-row channel delay taps and the raster position.
  logic [sbs_pkg::FRAC_W-1:0] shadow_frac_x    = '0;
  logic [sbs_pkg::FRAC_W-1:0] shadow_frac_y    = '0;
  logic [sbs_pkg::CHAN_W-1:0] shadow_channels  = 3'd1;
  logic [sbs_pkg::GEOM_W-1:0] shadow_row_bytes = 13'd64;
  logic [sbs_pkg::GEOM_W-1:0] shadow_row_count = 13'd1;
  logic [7:0]                 row_above [MAX_RB];
  logic [7:0]                 cur_taps  [MAX_CH];
  logic [7:0]                 prev_taps [MAX_CH];
  int unsigned                col_pos = 0;
  int unsigned                row_pos = 0;

  // Geometry as the hardware sees it: out-of-range settings clamp.
  function automatic int unsigned eff_channels();
    if (shadow_channels == 0) return 1;
    if (shadow_channels > MAX_CH) return MAX_CH;
    return shadow_channels;
  endfunction

  function automatic int unsigned eff_row_bytes();
    if (shadow_row_bytes == 0) return 1;
    if (shadow_row_bytes > MAX_RB) return MAX_RB;
    return shadow_row_bytes;
  endfunction

  function automatic int unsigned eff_row_count();
    return (shadow_row_count == 0) ? 1 : shadow_row_count;
  endfunction

  // A geometry change in mid-frame pins the position to the last column/row.
  function automatic int unsigned sat_col();
    return (col_pos < eff_row_bytes()) ? col_pos : eff_row_bytes() - 1;
  endfunction

  function automatic int unsigned sat_row();
    return (row_pos < eff_row_count()) ? row_pos : eff_row_count();
  endfunction

  // Source bytes left until the frame closes; valid only while idle.
  function automatic int unsigned frame_remaining();
    return (eff_row_bytes() - sat_col()) +
           (eff_row_count() - sat_row()) * eff_row_bytes();
  endfunction

  // ---------------------------------------------------------------------
  // Clock and cycle watchdog
  // ---------------------------------------------------------------------
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: no progress, stopped after %0d cycles", $time, cycles);
      $display("** subpixel_bilinear_shift_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sample driver: a new transaction is offered only once the previous one
  // is taken, so a stalled byte never changes and valid never drops early.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        sample_valid <= 1'b1;
        sample       <= pending_samples.pop_front();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Output side back-pressure.
  always @(posedge clk) begin
    pixel_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Prediction: register writes and accepted sample transactions update the
  // shadow; bytes past row 0 and past the first pixel yield a blended byte.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : predict_pixels
    int unsigned ch, rb, rc, c, r;
    int unsigned tap_a, tap_b, tap_d, tap_e, fx, fy, acc;
    int          k;
    logic        last_col, last_frame;
    pixel_txn_t  want;
    if (!rst && cfg_we) begin
      reg_writes++;
      case (cfg_index)
        sbs_pkg::REG_FRAC_X:        shadow_frac_x    = cfg_data[sbs_pkg::FRAC_W-1:0];
        sbs_pkg::REG_FRAC_Y:        shadow_frac_y    = cfg_data[sbs_pkg::FRAC_W-1:0];
        sbs_pkg::REG_CHANNEL_COUNT: shadow_channels  = cfg_data[sbs_pkg::CHAN_W-1:0];
        sbs_pkg::REG_ROW_BYTES:     shadow_row_bytes = cfg_data[sbs_pkg::GEOM_W-1:0];
        sbs_pkg::REG_ROW_COUNT:     shadow_row_count = cfg_data[sbs_pkg::GEOM_W-1:0];
        default: ;
      endcase
    end
    if (!rst && sample_valid && !sample_stall) begin
      ch = eff_channels();
      rb = eff_row_bytes();
      rc = eff_row_count();
      c  = sat_col();
      r  = sat_row();
      // a: above-left, b: above, d: left, e: this byte
      tap_e = sample;
      tap_b = row_above[c];
      tap_a = prev_taps[ch - 1];
      tap_d = cur_taps[ch - 1];
      for (k = MAX_CH - 1; k > 0; k--) begin
        cur_taps[k]  = cur_taps[k - 1];
        prev_taps[k] = prev_taps[k - 1];
      end
      cur_taps[0]  = sample;
      prev_taps[0] = row_above[c];
      row_above[c] = sample;
      last_col   = (c == rb - 1);
      last_frame = last_col && (r == rc);
      if (r >= 1 && c >= ch) begin
        fx  = shadow_frac_x;
        fy  = shadow_frac_y;
        acc = tap_a * (ONE - fx) * (ONE - fy) + tap_b * fx * (ONE - fy)
            + tap_d * (ONE - fx) * fy + tap_e * fx * fy + (1 << (2 * FB - 1));
        want.pixel      = 8'(acc >> (2 * FB));
        want.row_last   = last_col;
        want.frame_last = last_frame;
        expected_pixels.push_back(want);
      end
      if (last_frame) frames_done++;
      if (last_col) begin
        col_pos = 0;
        row_pos = last_frame ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
      bytes_in++;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each accepted pixel transaction against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    pixel_txn_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (expected_pixels.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= MAX_REPORTS)
          $display({"%0t: unexpected pixel: expected none, ",
                    "got pixel %0d row_last %0b frame_last %0b"},
                   $time, pixel, row_last, frame_last);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel !== want.pixel || row_last !== want.row_last ||
            frame_last !== want.frame_last) begin
          bad_pixels++;
          if (bad_pixels <= MAX_REPORTS)
            $display({"%0t: pixel mismatch: expected %0d/%0b/%0b, ",
                      "got %0d/%0b/%0b (pixel/row_last/frame_last)"},
                     $time, want.pixel, want.row_last, want.frame_last,
                     pixel, row_last, frame_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [sbs_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[sbs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random bytes, a quarter of them pinned to 0x00 or 0xFF
  task automatic queue_bytes(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(7))
        0:       pending_samples.push_back(8'h00);
        1:       pending_samples.push_back(8'hFF);
        default: pending_samples.push_back(8'($urandom));
      endcase
    end
  endtask

  // Checked on the falling edge so the queues and valid are settled; then
  // extra cycles for bytes still in the pipe that produce nothing.
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic finish_frame();
    queue_bytes(frame_remaining());
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_bytes, left, n, junk;
    random_bytes = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 64-byte rows, two source rows, no shift (output = a);
    // this also writes the first 64 line store entries that later rows read
    finish_frame();

    // maximum horizontal fraction, four channels
    write_reg(sbs_pkg::REG_FRAC_X, 15);
    write_reg(sbs_pkg::REG_FRAC_Y, 0);
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 4);
    write_reg(sbs_pkg::REG_ROW_BYTES, 40);
    write_reg(sbs_pkg::REG_ROW_COUNT, 1);
    finish_frame();

    // five-byte rows, vertical only, zero row count acts as one
    write_reg(sbs_pkg::REG_FRAC_X, 0);
    write_reg(sbs_pkg::REG_FRAC_Y, 15);
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 1);
    write_reg(sbs_pkg::REG_ROW_BYTES, 5);
    write_reg(sbs_pkg::REG_ROW_COUNT, 0);
    finish_frame();

    // both fractions at max, one output column per row
    write_reg(sbs_pkg::REG_FRAC_X, 15);
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 4);
    write_reg(sbs_pkg::REG_ROW_COUNT, 2);
    finish_frame();

    // channel count zero clamps to one
    write_reg(sbs_pkg::REG_FRAC_X, 8);
    write_reg(sbs_pkg::REG_FRAC_Y, 3);
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 0);
    write_reg(sbs_pkg::REG_ROW_BYTES, 7);
    write_reg(sbs_pkg::REG_ROW_COUNT, 1);
    finish_frame();

    // channel count 7 clamps to four; rows no wider than a pixel are silent
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 7);
    write_reg(sbs_pkg::REG_ROW_BYTES, 3);
    write_reg(sbs_pkg::REG_ROW_COUNT, 2);
    finish_frame();
    write_reg(sbs_pkg::REG_ROW_BYTES, 0);
    finish_frame();

    // row count cut in mid-frame: position pins to the new last row
    write_reg(sbs_pkg::REG_FRAC_Y, 8);
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 2);
    write_reg(sbs_pkg::REG_ROW_BYTES, 5);
    write_reg(sbs_pkg::REG_ROW_COUNT, 8191);
    queue_bytes(17);
    drain();
    write_reg(sbs_pkg::REG_ROW_COUNT, 2);
    finish_frame();

    // oversized row clamps to the store size, then shrinks in mid-row so the
    // column pins to the last one; channels and row count change mid-frame
    write_reg(sbs_pkg::REG_ROW_BYTES, 8191);
    write_reg(sbs_pkg::REG_ROW_COUNT, MAX_RB);
    queue_bytes(10);
    drain();
    write_reg(sbs_pkg::REG_ROW_BYTES, 6);
    queue_bytes(9);
    drain();
    write_reg(sbs_pkg::REG_CHANNEL_COUNT, 3);
    queue_bytes(4);
    drain();
    write_reg(sbs_pkg::REG_ROW_COUNT, 1);
    finish_frame();

    // Random frames: mostly complete frames with fresh settings, one in ten
    // cut short so the next settings land in mid-frame. Idling swaps sides
    // after a third and stops for the last third.
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes >= 2 * RANDOM_BYTES / 3) begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
      end else if (random_bytes >= RANDOM_BYTES / 3) begin
        sender_gap_pct     = 78;
        receiver_stall_pct = 23;
      end
      // upper data bits on the narrow registers should be ignored
      junk = ($urandom_range(9) == 0) ? $urandom_range(511) << sbs_pkg::FRAC_W : 0;
      if ($urandom_range(1)) write_reg(sbs_pkg::REG_FRAC_X, $urandom_range(15) | junk);
      if ($urandom_range(1)) write_reg(sbs_pkg::REG_FRAC_Y, $urandom_range(15) | junk);
      if ($urandom_range(1))
        write_reg(sbs_pkg::REG_CHANNEL_COUNT, ($urandom_range(7) == 0) ?
                  $urandom_range(7) | junk : $urandom_range(1, MAX_CH));
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:       write_reg(sbs_pkg::REG_ROW_BYTES, $urandom_range(4));
          1:       write_reg(sbs_pkg::REG_ROW_BYTES, $urandom_range(25, 64));
          default: write_reg(sbs_pkg::REG_ROW_BYTES, $urandom_range(5, 24));
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:       write_reg(sbs_pkg::REG_ROW_COUNT, 0);
          1:       write_reg(sbs_pkg::REG_ROW_COUNT, $urandom_range(5, 8));
          default: write_reg(sbs_pkg::REG_ROW_COUNT, $urandom_range(1, 4));
        endcase
      end
      if ($urandom_range(9) == 0)
        write_reg(sbs_pkg::CFG_INDEX_W'(REG_SPARE_FIRST + $urandom_range(2)),
                  $urandom_range(8191));
      left = frame_remaining();
      n = ($urandom_range(9) == 0) ? $urandom_range(1, left) : left;
      queue_bytes(n);
      random_bytes += n;
      drain();
    end

    drain();
    $display("%0d source bytes sent, %0d interpolated bytes checked, %0d frames closed",
             bytes_in, pixels_checked, frames_done);
    $display("%0d register writes across directed and random settings, %0d mismatches",
             reg_writes, bad_pixels);
    if (bad_pixels == 0) begin
      $display("** subpixel_bilinear_shift_unit: PASSED **");
    end else begin
      $display("** subpixel_bilinear_shift_unit: FAILED **");
    end
    $finish;
  end

endmodule
